>>> hdl/fnc_pkg.sv
// ----------------------------------------------------------------------------
// fnc_pkg: shared types and constants
// Item, atom and state types, widths and helper functions for the block.
// ----------------------------------------------------------------------------
package fnc_pkg;

	localparam int MAX_ATOMS    = 1024;
	localparam int MAX_CONTACTS = 65536;

	localparam int ADDR_W  = $clog2(MAX_ATOMS);
	localparam int IDX_W   = 11;
	localparam int COORD_W = 24;
	localparam int NAT_W   = 24;
	localparam int MAG_W   = 24;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int D2_W    = SQ_W + 2;
	localparam int CMP_W   = D2_W + 6;
	localparam int CNT_W   = 17;
	localparam int FRAC_SH = 16;
	localparam int DVD_W   = CNT_W + FRAC_SH;
	localparam int DCNT_W  = $clog2(DVD_W);
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam int CAP_INT = (MAX_CONTACTS < 131071) ? MAX_CONTACTS : 131071;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_CONTACT = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} atom_t;

	typedef struct packed {
		op_t               op;
		logic              a_ok;
		logic [ADDR_W-1:0] a_addr;
		logic              b_ok;
		logic [ADDR_W-1:0] b_addr;
		atom_t             coord;
		logic [NAT_W-1:0]  native;
		logic              last;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIFF,
		BK_SQR,
		BK_SCALE,
		BK_CMP,
		BK_DIV,
		BK_OUT
	} bk_state_t;

	function automatic logic slot_ok(input logic [IDX_W-1:0] idx);
		return (idx != '0) && (idx <= IDX_W'(MAX_ATOMS));
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] z;
		z = idx - IDX_W'(1);
		return z[ADDR_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
		return m[MAG_W-1:0];
	endfunction

endpackage

>>> hdl/fnc_front.sv
// ----------------------------------------------------------------------------
// fnc_front: input acceptance and classification
// Takes input beats, checks atom indices, forms zero-based addresses and
// pushes one decoded item into the queue.
// ----------------------------------------------------------------------------
module fnc_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic [10:0]                atom_index,
	input  logic signed [23:0]         coord_x,
	input  logic signed [23:0]         coord_y,
	input  logic signed [23:0]         coord_z,
	input  logic [10:0]                first_atom,
	input  logic [10:0]                second_atom,
	input  logic [23:0]                native_distance,
	input  logic                       last_contact,
	input  logic                       q_full,
	output logic                       push,
	output fnc_pkg::item_t             push_item
);

	fnc_pkg::op_t                    op;
	logic [fnc_pkg::IDX_W-1:0]       a_idx;

	assign op       = fnc_pkg::op_t'(operation);
	assign a_idx    = (op == fnc_pkg::OP_WRITE) ? atom_index : first_atom;
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.op     = op;
		push_item.a_ok   = fnc_pkg::slot_ok(a_idx);
		push_item.a_addr = fnc_pkg::slot_addr(a_idx);
		push_item.b_ok   = fnc_pkg::slot_ok(second_atom);
		push_item.b_addr = fnc_pkg::slot_addr(second_atom);
		push_item.coord  = '{x: coord_x, y: coord_y, z: coord_z};
		push_item.native = native_distance;
		push_item.last   = last_contact;
	end

endmodule

>>> hdl/fnc_queue.sv
// ----------------------------------------------------------------------------
// fnc_queue: decoded item queue
// Short first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module fnc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fnc_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output fnc_pkg::item_t head_item
);

	fnc_pkg::item_t                ent_q [fnc_pkg::QDEPTH];
	logic [fnc_pkg::QPTR_W-1:0]    wp_q;
	logic [fnc_pkg::QPTR_W-1:0]    rp_q;
	logic [fnc_pkg::QPTR_W:0]      cnt_q;

	assign full       = (cnt_q == (fnc_pkg::QPTR_W+1)'(fnc_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + fnc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + fnc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (fnc_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (fnc_pkg::QPTR_W+1)'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head_valid) || (push && full && !pop) |-> 1'b0)
		else $error("queue pushed while full or popped while empty");

endmodule

>>> hdl/fnc_back.sv
// ----------------------------------------------------------------------------
// fnc_back: atom store, contact evaluation and fraction
// Writes coordinates, squares distances through one shared multiplier,
// counts formed contacts and divides bit-serially on the last contact.
// ----------------------------------------------------------------------------
module fnc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  fnc_pkg::item_t                   q_item,
	output logic                             q_pop,
	output logic [fnc_pkg::CNT_W-1:0]        formed_fraction,
	output logic [fnc_pkg::CNT_W-1:0]        formed_count,
	output logic [fnc_pkg::CNT_W-1:0]        total_count,
	output logic                             out_valid,
	input  logic                             out_stall
);

	fnc_pkg::bk_state_t              state_q, state_d;

	fnc_pkg::atom_t                  mem_q [fnc_pkg::MAX_ATOMS];
	fnc_pkg::atom_t                  rda_q, rdb_q;
	fnc_pkg::atom_t                  pa, pb;

	logic                            a_ok_q, b_ok_q, last_q;
	logic [fnc_pkg::NAT_W-1:0]       nat_q;
	logic [1:0]                      step_q;
	logic [fnc_pkg::MAG_W-1:0]       magx_q, magy_q, magz_q;
	logic [fnc_pkg::MAG_W-1:0]       mul_op;
	logic [fnc_pkg::SQ_W-1:0]        prod_q;
	logic [fnc_pkg::D2_W-1:0]        d2_q;
	logic [fnc_pkg::CMP_W-1:0]       lhs_q, rhs_q;

	logic [fnc_pkg::CNT_W-1:0]       formed_q, total_q;
	logic [fnc_pkg::CNT_W-1:0]       frm_n, tot_n;

	logic [fnc_pkg::DVD_W-1:0]       dvd_q;
	logic [fnc_pkg::CNT_W-1:0]       dvs_q, fsnap_q, rem_q, quo_q;
	logic [fnc_pkg::CNT_W:0]         trial, trial_sub;
	logic [fnc_pkg::DCNT_W-1:0]      dcnt_q;

	logic [fnc_pkg::CNT_W-1:0]       frac_q, fcnt_q, tcnt_q;
	logic                            ovalid_q;

	logic                            mem_we, start, load_out, div_done, cnt_upd;

	// next state and control
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		start    = 1'b0;
		load_out = 1'b0;
		cnt_upd  = 1'b0;
		div_done = (dcnt_q == fnc_pkg::DCNT_W'(fnc_pkg::DVD_W - 1));
		unique case (state_q)
			fnc_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.op == fnc_pkg::OP_WRITE) begin
						mem_we = q_item.a_ok;
					end else begin
						start   = 1'b1;
						state_d = fnc_pkg::BK_DIFF;
					end
				end
			end
			fnc_pkg::BK_DIFF: state_d = fnc_pkg::BK_SQR;
			fnc_pkg::BK_SQR: begin
				if (step_q == 2'd3) begin
					state_d = fnc_pkg::BK_SCALE;
				end
			end
			fnc_pkg::BK_SCALE: state_d = fnc_pkg::BK_CMP;
			fnc_pkg::BK_CMP: begin
				cnt_upd = 1'b1;
				state_d = last_q ? fnc_pkg::BK_DIV : fnc_pkg::BK_IDLE;
			end
			fnc_pkg::BK_DIV: begin
				if (div_done) begin
					state_d = fnc_pkg::BK_OUT;
				end
			end
			fnc_pkg::BK_OUT: begin
				if (!ovalid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = fnc_pkg::BK_IDLE;
				end
			end
			default: state_d = fnc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// atom store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[q_item.a_addr] <= q_item.coord;
		end
		if (start) begin
			rda_q <= mem_q[q_item.a_addr];
			rdb_q <= mem_q[q_item.b_addr];
		end
	end

	// out-of-range atoms read as the origin
	assign pa = a_ok_q ? rda_q : '0;
	assign pb = b_ok_q ? rdb_q : '0;

	always_comb begin
		unique case (step_q)
			2'd0: mul_op = magx_q;
			2'd1: mul_op = magy_q;
			2'd2: mul_op = magz_q;
			default: mul_op = nat_q;
		endcase
	end

	always_comb begin
		tot_n = total_q;
		frm_n = formed_q;
		if (total_q < fnc_pkg::COUNT_CAP) begin
			tot_n = total_q + fnc_pkg::CNT_W'(1);
			if ((lhs_q < rhs_q) && (formed_q < fnc_pkg::COUNT_CAP)) begin
				frm_n = formed_q + fnc_pkg::CNT_W'(1);
			end
		end
	end

	assign trial     = {rem_q, dvd_q[fnc_pkg::DVD_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_ok_q <= q_item.a_ok;
			b_ok_q <= q_item.b_ok;
			nat_q  <= q_item.native;
			last_q <= q_item.last;
		end
		if (state_q == fnc_pkg::BK_DIFF) begin
			magx_q <= fnc_pkg::abs_diff(pa.x, pb.x);
			magy_q <= fnc_pkg::abs_diff(pa.y, pb.y);
			magz_q <= fnc_pkg::abs_diff(pa.z, pb.z);
			d2_q   <= '0;
		end
		if (state_q == fnc_pkg::BK_SQR) begin
			prod_q <= mul_op * mul_op;
			if (step_q != 2'd0) begin
				d2_q <= d2_q + fnc_pkg::D2_W'(prod_q);
			end
		end
		if (state_q == fnc_pkg::BK_SCALE) begin
			lhs_q <= (fnc_pkg::CMP_W'(d2_q) << 4) + (fnc_pkg::CMP_W'(d2_q) << 3)
				+ fnc_pkg::CMP_W'(d2_q);
			rhs_q <= (fnc_pkg::CMP_W'(prod_q) << 5) + (fnc_pkg::CMP_W'(prod_q) << 2);
		end
		if (cnt_upd && last_q) begin
			dvs_q   <= tot_n;
			fsnap_q <= frm_n;
			dvd_q   <= {frm_n, fnc_pkg::FRAC_SH'(0)};
			rem_q   <= '0;
			quo_q   <= '0;
		end
		if (state_q == fnc_pkg::BK_DIV) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial_sub[fnc_pkg::CNT_W-1:0];
				quo_q <= {quo_q[fnc_pkg::CNT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[fnc_pkg::CNT_W-1:0];
				quo_q <= {quo_q[fnc_pkg::CNT_W-2:0], 1'b0};
			end
		end
		if (load_out) begin
			frac_q <= quo_q;
			fcnt_q <= fsnap_q;
			tcnt_q <= dvs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			dcnt_q   <= '0;
			formed_q <= '0;
			total_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == fnc_pkg::BK_SQR) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
			if (state_q == fnc_pkg::BK_DIV) begin
				dcnt_q <= dcnt_q + fnc_pkg::DCNT_W'(1);
			end else begin
				dcnt_q <= '0;
			end
			if (cnt_upd) begin
				formed_q <= last_q ? '0 : frm_n;
				total_q  <= last_q ? '0 : tot_n;
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign formed_fraction = frac_q;
	assign formed_count    = fcnt_q;
	assign total_count     = tcnt_q;
	assign out_valid       = ovalid_q;

	a_formed_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		formed_q <= total_q)
		else $error("formed count above total count");

	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q) == fnc_pkg::BK_OUT)
		else $error("result raised outside the output step");

	a_frac_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (tcnt_q != '0) &&
		((frac_q == fnc_pkg::CNT_W'(1 << fnc_pkg::FRAC_SH)) == (fcnt_q == tcnt_q)))
		else $error("fraction disagrees with counts");

endmodule

>>> hdl/fraction_native_contacts_top.sv
// ----------------------------------------------------------------------------
// fraction_native_contacts_top: fraction of native contacts
// Atom coordinate store and contact evaluator giving the formed fraction.
// ----------------------------------------------------------------------------
// In the back end a coordinate write is handled in the idle state; a contact
// is taken through difference, then squaring on the single 24x24 squaring
// multiplier shared over the three axes and the native distance, then scaling
// and compare. The last contact of a list adds a bit-serial division and a
// load of the result register. A 4-entry queue sits between the input and the
// back end, so beats are taken, until it fills, while the back end works or a result waits.
module fraction_native_contacts_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [10:0]         atom_index,
	input  logic signed [23:0]  coord_x,
	input  logic signed [23:0]  coord_y,
	input  logic signed [23:0]  coord_z,
	input  logic [10:0]         first_atom,
	input  logic [10:0]         second_atom,
	input  logic [23:0]         native_distance,
	input  logic                last_contact,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [16:0]         formed_fraction,
	output logic [16:0]         formed_count,
	output logic [16:0]         total_count
);

	logic            q_full, push, q_valid, q_pop;
	fnc_pkg::item_t  push_item, head_item;

	fnc_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.atom_index      (atom_index),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.first_atom      (first_atom),
		.second_atom     (second_atom),
		.native_distance (native_distance),
		.last_contact    (last_contact),
		.q_full          (q_full),
		.push            (push),
		.push_item       (push_item)
	);

	fnc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (head_item)
	);

	fnc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (head_item),
		.q_pop           (q_pop),
		.formed_fraction (formed_fraction),
		.formed_count    (formed_count),
		.total_count     (total_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall)
	);

endmodule
